// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants and types of the serial line editor: character codes,
// command kinds passed from the front part to the back part, back-part states.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_BYTES_DEFAULT = 64;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        CMD_ECHO,
        CMD_ERASE,
        CMD_LINE
    } kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } bk_state_t;

endpackage

// ===== design/sle_if.sv =====
// ----------------------------------------------------------------------------
// sle_in_if / sle_out_if
// Valid/ready channels of the serial line editor: received bytes in,
// echo and line items out.
// ----------------------------------------------------------------------------
interface sle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_out_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       line_end;
    logic       last;

    modport source (output valid, output echo_valid, output echo_byte,
                    output line_valid, output line_byte, output line_end,
                    output last, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte,
                    input line_valid, input line_byte, input line_end,
                    input last, output ready);
endinterface

// ===== design/sle_ram.sv =====
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Accepts received bytes, classifies them, keeps the fill position, writes
// ordinary characters into the line store and issues commands to the back.
// ----------------------------------------------------------------------------
module sle_front #(
    parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEFAULT,
    localparam int POS_W     = $clog2(LINE_BYTES),
    localparam int ADDR_W    = $clog2(LINE_BYTES - 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    sle_in_if.sink              rx,
    input  logic                q_full,
    input  logic                line_done,
    output logic                push,
    output sle_pkg::kind_t      cmd_kind,
    output logic [7:0]          cmd_data,
    output logic [POS_W-1:0]    cmd_pos,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [7:0]          wr_data
);

    import sle_pkg::*;

    logic [POS_W-1:0] fill_pos_reg, fill_pos_next;
    logic             line_busy_reg, line_busy_next;
    logic             accept;
    logic             is_erase;
    logic             is_term;

    // hold off while a line read-out is pending: it reads the store
    assign rx.ready = !q_full && !line_busy_reg;
    assign accept   = rx.valid && rx.ready;
    assign is_erase = (rx.rx_byte == CH_BS) || (rx.rx_byte == CH_DEL);
    assign is_term  = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);

    assign cmd_data = rx.rx_byte;
    assign cmd_pos  = fill_pos_reg;
    assign wr_addr  = fill_pos_reg[ADDR_W-1:0];
    assign wr_data  = rx.rx_byte;

    always_comb
    begin
        fill_pos_next  = fill_pos_reg;
        line_busy_next = line_busy_reg;
        push           = 1'b0;
        cmd_kind       = CMD_ECHO;
        wr_en          = 1'b0;
        if (line_done)
        begin
            line_busy_next = 1'b0;
        end
        if (accept)
        begin
            if (is_erase)
            begin
                // drop a backspace on an empty line
                if (fill_pos_reg != '0)
                begin
                    fill_pos_next = fill_pos_reg - 1'b1;
                    push          = 1'b1;
                    cmd_kind      = CMD_ERASE;
                end
            end
            else if (is_term)
            begin
                push           = 1'b1;
                cmd_kind       = CMD_LINE;
                fill_pos_next  = '0;
                line_busy_next = 1'b1;
            end
            else
            begin
                push = 1'b1;
                if (fill_pos_reg < POS_W'(LINE_BYTES - 1))
                begin
                    wr_en         = 1'b1;
                    fill_pos_next = fill_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pos_reg  <= '0;
            line_busy_reg <= 1'b0;
        end
        else
        begin
            fill_pos_reg  <= fill_pos_next;
            line_busy_reg <= line_busy_next;
        end
    end

endmodule

// ===== design/sle_queue.sv =====
// ----------------------------------------------------------------------------
// sle_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sle_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sle_pkg::QUEUE_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Carries out queued commands: produces the echo run, or the echo plus the
// stored line from the line store, one item per cycle while not stalled.
// ----------------------------------------------------------------------------
module sle_back #(
    parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEFAULT,
    localparam int POS_W     = $clog2(LINE_BYTES),
    localparam int ADDR_W    = $clog2(LINE_BYTES - 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  sle_pkg::kind_t      q_kind,
    input  logic [7:0]          q_data,
    input  logic [POS_W-1:0]    q_pos,
    output logic                pop,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    input  logic [7:0]          rd_data,
    output logic                line_done,
    sle_out_if.source           tx
);

    import sle_pkg::*;

    bk_state_t        state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       data_reg, data_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] k_reg, k_next;
    logic [POS_W:0]   k_inc;
    logic [POS_W-1:0] last_idx;

    logic             out_valid_reg, out_valid_next;
    logic             echo_valid_reg, echo_valid_next;
    logic [7:0]       echo_byte_reg, echo_byte_next;
    logic             line_valid_reg, line_valid_next;
    logic [7:0]       line_byte_reg, line_byte_next;
    logic             line_end_reg, line_end_next;
    logic             last_reg, last_next;

    logic             slot_free;
    logic             it_echo_valid;
    logic [7:0]       it_echo_byte;
    logic             it_line_valid;
    logic [7:0]       it_line_byte;
    logic             it_line_end;

    assign slot_free = !out_valid_reg || tx.ready;
    assign k_inc     = {1'b0, k_reg} + 1'b1;

    // index of the final item of the run
    always_comb
    begin
        unique case (kind_reg)
            CMD_ECHO:  last_idx = '0;
            CMD_ERASE: last_idx = POS_W'(2);
            CMD_LINE:  last_idx = (pos_reg > POS_W'(2)) ? pos_reg : POS_W'(2);
            default:   last_idx = '0;
        endcase
    end

    // fields of item k of the current run
    always_comb
    begin
        it_echo_valid = 1'b0;
        it_echo_byte  = '0;
        it_line_valid = 1'b0;
        it_line_byte  = '0;
        it_line_end   = 1'b0;
        unique case (kind_reg)
            CMD_ECHO:
            begin
                it_echo_valid = 1'b1;
                it_echo_byte  = data_reg;
            end
            CMD_ERASE:
            begin
                it_echo_valid = 1'b1;
                it_echo_byte  = (k_reg == POS_W'(1)) ? CH_SP : CH_BS;
            end
            CMD_LINE:
            begin
                if (k_reg < POS_W'(3))
                begin
                    it_echo_valid = 1'b1;
                    if (k_reg == '0)
                    begin
                        it_echo_byte = data_reg;
                    end
                    else if (k_reg == POS_W'(1))
                    begin
                        it_echo_byte = CH_CR;
                    end
                    else
                    begin
                        it_echo_byte = CH_LF;
                    end
                end
                if (k_reg < pos_reg)
                begin
                    it_line_valid = 1'b1;
                    it_line_byte  = rd_data;
                end
                else if (k_reg == pos_reg)
                begin
                    it_line_valid = 1'b1;
                    it_line_end   = 1'b1;
                end
            end
            default:
            begin
                it_echo_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        data_next       = data_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        line_done       = 1'b0;
        out_valid_next  = out_valid_reg && !tx.ready;
        echo_valid_next = echo_valid_reg;
        echo_byte_next  = echo_byte_reg;
        line_valid_next = line_valid_reg;
        line_byte_next  = line_byte_reg;
        line_end_next   = line_end_reg;
        last_next       = last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    kind_next  = q_kind;
                    data_next  = q_data;
                    pos_next   = q_pos;
                    k_next     = '0;
                    state_next = BK_EMIT;
                    if (q_kind == CMD_LINE && q_pos != '0)
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    echo_valid_next = it_echo_valid;
                    echo_byte_next  = it_echo_byte;
                    line_valid_next = it_line_valid;
                    line_byte_next  = it_line_byte;
                    line_end_next   = it_line_end;
                    last_next       = (k_reg == last_idx);
                    if (k_reg == last_idx)
                    begin
                        state_next = BK_IDLE;
                        line_done  = (kind_reg == CMD_LINE);
                    end
                    else
                    begin
                        k_next = k_inc[POS_W-1:0];
                        // fetch the next stored character ahead of its item
                        if (kind_reg == CMD_LINE && k_inc < {1'b0, pos_reg})
                        begin
                            rd_en   = 1'b1;
                            rd_addr = k_inc[ADDR_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        data_reg       <= data_next;
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        echo_valid_reg <= echo_valid_next;
        echo_byte_reg  <= echo_byte_next;
        line_valid_reg <= line_valid_next;
        line_byte_reg  <= line_byte_next;
        line_end_reg   <= line_end_next;
        last_reg       <= last_next;
    end

    assign tx.valid      = out_valid_reg;
    assign tx.echo_valid = echo_valid_reg;
    assign tx.echo_byte  = echo_byte_reg;
    assign tx.line_valid = line_valid_reg;
    assign tx.line_byte  = line_byte_reg;
    assign tx.line_end   = line_end_reg;
    assign tx.last       = last_reg;

endmodule

// ===== design/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor
// Terminal line editor: echoes received bytes, handles backspace, and on
// CR or LF delivers the stored line followed by a zero terminator item.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                       handshake
//  rx       in         rx_byte                                       valid/ready
//  tx       out        echo_valid echo_byte line_valid line_byte     valid/ready
//                      line_end last
//
//  An ordinary byte gives one item, a backspace three (none on an empty
//  line), a line terminator max(3, fill+1) items. The back part takes a
//  command from the queue only in its idle state, once the previous one
//  is done, then emits one item per cycle while tx is not stalled.
//  While a line is being read out, rx.ready stays low; otherwise a new byte
//  is taken whenever the two-entry command queue has room.
//  Reset clears the fill position, the queue and the output register; the
//  line store is not cleared. A stalled tx holds its item and stalls the back.
//
module serial_line_editor #(
    parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    sle_in_if.sink      rx,
    sle_out_if.source   tx
);

    import sle_pkg::*;

    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int ADDR_W = $clog2(LINE_BYTES - 1);
    localparam int CMD_W  = KIND_W + 8 + POS_W;

    logic              push;
    kind_t             cmd_kind;
    logic [7:0]        cmd_data;
    logic [POS_W-1:0]  cmd_pos;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic [CMD_W-1:0]  q_dout;
    kind_t             q_kind;
    logic [7:0]        q_data;
    logic [POS_W-1:0]  q_pos;
    logic              line_done;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    sle_front #(.LINE_BYTES(LINE_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_full    (q_full),
        .line_done (line_done),
        .push      (push),
        .cmd_kind  (cmd_kind),
        .cmd_data  (cmd_data),
        .cmd_pos   (cmd_pos),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sle_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({cmd_kind, cmd_data, cmd_pos}),
        .pop   (pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_kind = kind_t'(q_dout[CMD_W-1 -: KIND_W]);
    assign q_data = q_dout[POS_W +: 8];
    assign q_pos  = q_dout[POS_W-1:0];

    sle_ram #(.WIDTH(8), .DEPTH(LINE_BYTES - 1)) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sle_back #(.LINE_BYTES(LINE_BYTES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_kind    (q_kind),
        .q_data    (q_data),
        .q_pos     (q_pos),
        .pop       (pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .line_done (line_done),
        .tx        (tx)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full || pop)
        else $error("command queue overrun");

    a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("command queue underrun");

    a_line_done_last : assert property (@(posedge clk) disable iff (!rst_n)
        line_done |=> tx.valid && tx.last)
        else $error("line read-out did not close with its final item");

    a_item_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid |-> tx.echo_valid || tx.line_valid)
        else $error("result item carries neither echo nor line data");

    a_end_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.line_end |-> tx.line_valid && tx.line_byte == 8'h00)
        else $error("line terminator item malformed");

endmodule
